[rtl/aged_pool_slot_allocator_unit_assert.svh]
// Assertion macros shared by the slot allocator RTL.
`ifndef AGED_POOL_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define AGED_POOL_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on i_clk and quiet during reset.
`define APSA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot allocator check failed");

// Next-cycle implication, clocked on i_clk and quiet during reset.
`define APSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot allocator check failed");

`endif

[rtl/apsa_pkg.sv]
// Package with sizes, codes and types of the slot allocator.
package apsa_pkg;

    localparam int NUM_POOLS  = 8;
    localparam int POOL_DEPTH = 4;
    localparam int AGE_WINDOW = 2;

    localparam int POOL_W  = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int IDX_W   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
    localparam int ENTRIES = NUM_POOLS * POOL_DEPTH;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int LEVEL_W  = 4;
    localparam int OWNER_W  = 8;
    localparam int KEY_W    = 32;
    localparam int FRAME_W  = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 2;

    localparam int ENTRY_W   = OWNER_W + KEY_W + FRAME_W;
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;

    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_REQ  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_IDLE_REUSE = 3'd0,
        STAT_SHARED     = 3'd1,
        STAT_STALE      = 3'd2,
        STAT_APPEND     = 3'd3,
        STAT_EVICT      = 3'd4,
        STAT_REJECT     = 3'd5,
        STAT_NOALLOC    = 3'd6
    } t_status;

endpackage

[rtl/apsa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module apsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/aged_pool_slot_allocator_unit.sv]
// Top level of the aged buffer pool slot allocator.
// Keeps NUM_POOLS pools of POOL_DEPTH slots; every slot's owner, format key and
// last-used frame live in one slot RAM with a registered read. A tick word
// (tuser = 0) yields no result. A request word (tuser = 1) yields one result
// word: a rejected request goes straight to S_FINISH; a request on a pool
// holding slots runs S_SCAN, which reads one slot per cycle through the single
// RAM read port, then S_DECIDE and S_FINISH, which loads the output register.
// An empty pool skips S_SCAN, and an idle match found in the scan skips
// S_DECIDE. A result that waits in the output register does not stop the next
// word from being taken; only the next result waits for it. Slot RAM contents
// need no clearing after reset, since a slot is read only once its pool's fill
// count covers it.
`include "aged_pool_slot_allocator_unit_assert.svh"

module aged_pool_slot_allocator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: pool_level[3:0], owner_id[11:4], format_key[43:12], alloc_ok[44], zeros
    input  logic [apsa_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: command[0]
    input  logic [apsa_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: status[2:0], slot[4:3], zeros
    output logic [apsa_pkg::M_TDATA_W-1:0] o_m_tdata
);

    import apsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    // Control registers.
    t_state             r_state, n_state;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [CNT_W-1:0]   r_fill [NUM_POOLS];
    logic               fill_inc;
    logic               r_ov, n_ov;
    logic               r_dv, n_dv;

    // Per-request working registers.
    logic [POOL_W-1:0]  r_pool, n_pool;
    logic [OWNER_W-1:0] r_owner, n_owner;
    logic [KEY_W-1:0]   r_key, n_key;
    logic               r_alloc, n_alloc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [FRAME_W-1:0] r_min, n_min;
    logic [CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]   r_didx, n_didx;
    logic               r_busy_v, n_busy_v;
    logic [IDX_W-1:0]   r_busy, n_busy;
    logic               r_stale_v, n_stale_v;
    logic [IDX_W-1:0]   r_stale, n_stale;
    logic [IDX_W-1:0]   r_lru, n_lru;
    logic [FRAME_W-1:0] r_oldest, n_oldest;
    t_status            r_status, n_status;
    logic [IDX_W-1:0]   r_slot, n_slot;
    t_status            r_ostat, n_ostat;
    logic [SLOT_W-1:0]  r_oslot, n_oslot;

    // Input word fields.
    logic               acc_in;
    logic               in_cmd;
    logic [LEVEL_W-1:0] in_pool;
    logic [OWNER_W-1:0] in_owner;
    logic [KEY_W-1:0]   in_key;
    logic               in_alloc;
    logic               req_ok;
    logic [CNT_W-1:0]   in_fill;

    // Slot RAM ports.
    logic               ram_we;
    logic [IDX_W-1:0]   w_slot;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [OWNER_W-1:0] rd_owner;
    logic [KEY_W-1:0]   rd_key;
    logic [FRAME_W-1:0] rd_frame;

    logic               m_own, m_key, m_old, hit, last, full;

    assign o_s_tready = (r_state == S_IDLE);
    assign acc_in     = i_s_tvalid && o_s_tready;

    assign in_cmd   = i_s_tuser[0];
    assign in_pool  = i_s_tdata[3:0];
    assign in_owner = i_s_tdata[11:4];
    assign in_key   = i_s_tdata[43:12];
    assign in_alloc = i_s_tdata[44];
    assign req_ok   = ({1'b0, in_pool} < (LEVEL_W + 1)'(NUM_POOLS)) && (in_owner != '0);
    assign in_fill  = r_fill[in_pool[POOL_W-1:0]];

    assign ram_raddr = ADDR_W'(r_pool) * ADDR_W'(POOL_DEPTH) + ADDR_W'(r_rd_idx[IDX_W-1:0]);
    assign ram_waddr = ADDR_W'(r_pool) * ADDR_W'(POOL_DEPTH) + ADDR_W'(w_slot);
    assign ram_wdata = {r_owner, r_key, r_frame};

    assign rd_frame = ram_rdata[FRAME_W-1:0];
    assign rd_key   = ram_rdata[FRAME_W+KEY_W-1:FRAME_W];
    assign rd_owner = ram_rdata[ENTRY_W-1:FRAME_W+KEY_W];

    // A slot is old enough when it was last used before the age window.
    assign m_own = (rd_owner == r_owner);
    assign m_key = (rd_key == r_key);
    assign m_old = (rd_frame < r_min);
    assign hit   = r_dv && m_own && m_key && m_old;
    assign last  = (CNT_W'(r_didx) + CNT_W'(1)) == r_cnt;
    assign full  = (r_cnt == CNT_W'(POOL_DEPTH));

    apsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES),
        .ADDR_W(ADDR_W)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_frame   = r_frame;
        n_ov      = r_ov;
        n_dv      = 1'b0;
        n_pool    = r_pool;
        n_owner   = r_owner;
        n_key     = r_key;
        n_alloc   = r_alloc;
        n_cnt     = r_cnt;
        n_min     = r_min;
        n_rd_idx  = r_rd_idx;
        n_didx    = r_didx;
        n_busy_v  = r_busy_v;
        n_busy    = r_busy;
        n_stale_v = r_stale_v;
        n_stale   = r_stale;
        n_lru     = r_lru;
        n_oldest  = r_oldest;
        n_status  = r_status;
        n_slot    = r_slot;
        n_ostat   = r_ostat;
        n_oslot   = r_oslot;
        ram_we    = 1'b0;
        w_slot    = '0;
        fill_inc  = 1'b0;

        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    if (in_cmd == CMD_TICK) begin
                        if (r_frame != FRAME_MAX) begin
                            n_frame = r_frame + FRAME_W'(1);
                        end
                    end else begin
                        n_pool    = in_pool[POOL_W-1:0];
                        n_owner   = in_owner;
                        n_key     = in_key;
                        n_alloc   = in_alloc;
                        n_cnt     = req_ok ? in_fill : '0;
                        n_min     = (r_frame >= FRAME_W'(AGE_WINDOW))
                                    ? r_frame - FRAME_W'(AGE_WINDOW) : '0;
                        n_rd_idx  = '0;
                        n_busy_v  = 1'b0;
                        n_stale_v = 1'b0;
                        n_lru     = '0;
                        if (!req_ok) begin
                            n_status = STAT_REJECT;
                            n_slot   = '0;
                            n_state  = S_FINISH;
                        end else if (in_fill == '0) begin
                            n_state = S_DECIDE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                // Reads are issued one slot per cycle; the data of the slot read
                // in the previous cycle is checked at the same time.
                if (r_rd_idx < r_cnt) begin
                    n_dv     = 1'b1;
                    n_didx   = r_rd_idx[IDX_W-1:0];
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
                if (r_dv) begin
                    if (hit) begin
                        ram_we   = 1'b1;
                        w_slot   = r_didx;
                        n_status = STAT_IDLE_REUSE;
                        n_slot   = r_didx;
                        n_dv     = 1'b0;
                        n_state  = S_FINISH;
                    end else begin
                        if (m_own && !m_key && m_old && !r_stale_v) begin
                            n_stale_v = 1'b1;
                            n_stale   = r_didx;
                        end
                        if (m_own && m_key && !r_busy_v) begin
                            n_busy_v = 1'b1;
                            n_busy   = r_didx;
                        end
                        if (r_didx == '0 || rd_frame < r_oldest) begin
                            n_oldest = rd_frame;
                            n_lru    = r_didx;
                        end
                        if (last) begin
                            n_state = S_DECIDE;
                        end
                    end
                end
            end
            S_DECIDE: begin
                n_state = S_FINISH;
                if (r_busy_v && full) begin
                    ram_we   = 1'b1;
                    w_slot   = r_busy;
                    n_status = STAT_SHARED;
                    n_slot   = r_busy;
                end else if (!r_alloc) begin
                    n_status = STAT_NOALLOC;
                    n_slot   = '0;
                end else if (r_stale_v) begin
                    ram_we   = 1'b1;
                    w_slot   = r_stale;
                    n_status = STAT_STALE;
                    n_slot   = r_stale;
                end else if (!full) begin
                    ram_we   = 1'b1;
                    w_slot   = r_cnt[IDX_W-1:0];
                    fill_inc = 1'b1;
                    n_status = STAT_APPEND;
                    n_slot   = r_cnt[IDX_W-1:0];
                end else begin
                    ram_we   = 1'b1;
                    w_slot   = r_lru;
                    n_status = STAT_EVICT;
                    n_slot   = r_lru;
                end
            end
            S_FINISH: begin
                if (!r_ov || i_m_tready) begin
                    n_ov    = 1'b1;
                    n_ostat = r_status;
                    n_oslot = SLOT_W'(r_slot);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_frame <= '0;
            r_ov    <= 1'b0;
            r_dv    <= 1'b0;
            for (int p = 0; p < NUM_POOLS; p++) begin
                r_fill[p] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_frame <= n_frame;
            r_ov    <= n_ov;
            r_dv    <= n_dv;
            if (fill_inc) begin
                r_fill[r_pool] <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pool    <= n_pool;
        r_owner   <= n_owner;
        r_key     <= n_key;
        r_alloc   <= n_alloc;
        r_cnt     <= n_cnt;
        r_min     <= n_min;
        r_rd_idx  <= n_rd_idx;
        r_didx    <= n_didx;
        r_busy_v  <= n_busy_v;
        r_busy    <= n_busy;
        r_stale_v <= n_stale_v;
        r_stale   <= n_stale;
        r_lru     <= n_lru;
        r_oldest  <= n_oldest;
        r_status  <= n_status;
        r_slot    <= n_slot;
        r_ostat   <= n_ostat;
        r_oslot   <= n_oslot;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {(M_TDATA_W - STATUS_W - SLOT_W)'(0), r_oslot, r_ostat};

    `APSA_ASSERT_NEXT(a_req_leaves_idle, acc_in && in_cmd == CMD_REQ, r_state != S_IDLE)
    `APSA_ASSERT_NEXT(a_tick_no_result, acc_in && in_cmd == CMD_TICK, !$rose(r_ov))
    `APSA_ASSERT_IMPL(a_scan_count_bound, r_state == S_SCAN, r_cnt != '0 && r_cnt <= CNT_W'(POOL_DEPTH))
    `APSA_ASSERT_IMPL(a_write_in_work_states, ram_we, r_state == S_SCAN || r_state == S_DECIDE)

endmodule
